// ===== hdl/dvfs_max_vote_aggregator_core_assert.svh =====
// Assertion macros used by the block's core module.
`ifndef DVFS_MAX_VOTE_AGGREGATOR_CORE_ASSERT_SVH
`define DVFS_MAX_VOTE_AGGREGATOR_CORE_ASSERT_SVH

`ifndef SYNTH

// Checked property, disabled while reset is high.
`define DMVA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dmva assertion failed");

// Checked property that also holds through reset.
`define DMVA_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("dmva assertion failed");

`else

`define DMVA_ASSERT(name, clk, rst, prop)
`define DMVA_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// ===== hdl/dmva_pkg.sv =====
`default_nettype none

package dmva_pkg;

   localparam int NUM_CLIENTS = 8;
   localparam int LEVEL_W     = 4;
   localparam int CLIENT_W    = 4;
   localparam int COUNT_W     = 32;
   localparam int CLIENT_IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;

   localparam logic [LEVEL_W-1:0] NO_VOTE     = LEVEL_W'(7);
   localparam logic [LEVEL_W-1:0] FLOOR_RESET = LEVEL_W'(1);

   typedef enum logic {
      OP_VOTE = 1'b0,
      OP_INIT = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_INVALID     = 2'd1,
      ST_NOT_READY   = 2'd2,
      ST_SWITCH_FAIL = 2'd3
   } status_type;

   typedef logic [NUM_CLIENTS-1:0][LEVEL_W-1:0] vote_table_type;

   // Reduction result over one vote table.
   typedef struct packed {
      logic [LEVEL_W-1:0] eff_level;
      logic               all_none;
   } vote_sum_type;

endpackage

`default_nettype wire

// ===== hdl/dmva_csr.sv =====
`default_nettype none

module dmva_csr
   import dmva_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic      [31:0]        csr_prdata,
   output logic                    csr_pready,
   output logic      [LEVEL_W-1:0] floor_level
);

   typedef enum logic {
      REG_FLOOR = 1'b0,
      REG_NONE  = 1'b1
   } reg_index_type;

   logic [LEVEL_W-1:0] floor_ff;
   logic [LEVEL_W-1:0] floor_in;
   reg_index_type      reg_sel;
   logic               wr_en;

   assign csr_pready  = 1'b1;
   assign reg_sel     = reg_index_type'(csr_paddr[2]);
   assign wr_en       = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign floor_level = floor_ff;

   always_comb begin
      floor_in    = floor_ff;
      csr_prdata  = '0;
      unique case (reg_sel)
         REG_FLOOR: begin
            csr_prdata = {{(32-LEVEL_W){1'b0}}, floor_ff};
            if (wr_en) begin
               floor_in = csr_pwdata[LEVEL_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= FLOOR_RESET;
      end else begin
         floor_ff <= floor_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/dmva_level_max.sv =====
`default_nettype none

module dmva_level_max
   import dmva_pkg::*;
(
   input  wire vote_table_type     votes,
   input  wire logic [LEVEL_W-1:0] floor_level,
   output vote_sum_type            sum
);

   // Withdrawn entries do not take part in the maximum.
   always_comb begin
      sum.eff_level = floor_level;
      sum.all_none  = 1'b1;
      for (int i = 0; i < NUM_CLIENTS; i++) begin
         if (votes[i] != NO_VOTE) begin
            sum.all_none = 1'b0;
            if (votes[i] > sum.eff_level) begin
               sum.eff_level = votes[i];
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/dvfs_max_vote_aggregator_core.sv =====
`default_nettype none

// Max-vote performance-level aggregator. Each client holds one vote; the effective level is
// the larger of floor_level and every vote that is not NO_VOTE. An init request clears all
// votes and loads the current and peak levels from the reported hardware level. A vote that
// moves the effective level asks for a switch, and switch_ok in the same request decides
// whether the level, peak and transition count follow or the vote is rolled back. Every
// request gives exactly one response, which passes the input register, then the result
// register; one request is taken per cycle when the response side keeps up. The eight-entry
// maximum over the vote table sets the path between the two registers.
// floor_level is written through the APB port at byte address 0 and should only change while
// no request is in flight.

`include "dvfs_max_vote_aggregator_core_assert.svh"

module dvfs_max_vote_aggregator_core
   import dmva_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // tdata: client[3:0], level[7:4], switch_ok[8], zero[15:9]
   input  wire logic [15:0] req_tdata,
   // tuser: opcode[0]
   input  wire logic [0:0]  req_tuser,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: switch_request[0], request_level[4:1], current_level[8:5],
   // peak_level[12:9], transition_count[44:13], all_withdrawn[45], zero[47:46]
   output logic [47:0]      rsp_tdata,
   // tuser: status[1:0]
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   logic [LEVEL_W-1:0] floor_level;

   // Input register.
   logic                in_valid_ff, in_valid_in;
   opcode_type          in_op_ff;
   logic [CLIENT_W-1:0] in_client_ff;
   logic [LEVEL_W-1:0]  in_level_ff;
   logic                in_ok_ff;

   // Architectural state.
   vote_table_type      votes_ff, votes_in;
   logic [LEVEL_W-1:0]  now_ff, now_in;
   logic [LEVEL_W-1:0]  peak_ff, peak_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                ready_ff, ready_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_sw_ff, rsp_sw_in;
   logic [LEVEL_W-1:0]  rsp_req_level_ff, rsp_req_level_in;
   logic                rsp_all_ff;

   logic                req_fire;
   logic                fire;
   logic                bad_arg;
   logic                commit_ok;
   vote_table_type      cand_votes;
   vote_sum_type        cand_sum;
   vote_sum_type        next_sum;
   logic [CLIENT_IDX_W-1:0] client_idx;

   dmva_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .floor_level (floor_level)
   );

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_fire   = req_tvalid && req_tready;

   assign client_idx = in_client_ff[CLIENT_IDX_W-1:0];
   assign bad_arg    = ({1'b0, in_client_ff} >= (CLIENT_W+1)'(NUM_CLIENTS))
                       || (in_level_ff > NO_VOTE);

   always_comb begin
      cand_votes             = votes_ff;
      cand_votes[client_idx] = in_level_ff;
   end

   dmva_level_max u_cand_max (
      .votes       (cand_votes),
      .floor_level (floor_level),
      .sum         (cand_sum)
   );

   always_comb begin
      votes_in         = votes_ff;
      now_in           = now_ff;
      peak_in          = peak_ff;
      count_in         = count_ff;
      ready_in         = ready_ff;
      rsp_status_in    = ST_OK;
      rsp_sw_in        = 1'b0;
      rsp_req_level_in = '0;
      commit_ok        = 1'b0;
      if (in_op_ff == OP_INIT) begin
         votes_in = {NUM_CLIENTS{NO_VOTE}};
         now_in   = in_level_ff;
         peak_in  = in_level_ff;
         ready_in = 1'b1;
      end else if (bad_arg) begin
         rsp_status_in = ST_INVALID;
      end else if (!ready_ff) begin
         rsp_status_in = ST_NOT_READY;
      end else if (cand_sum.eff_level == now_ff) begin
         votes_in = cand_votes;
      end else begin
         rsp_sw_in        = 1'b1;
         rsp_req_level_in = cand_sum.eff_level;
         if (in_ok_ff) begin
            commit_ok = 1'b1;
            votes_in  = cand_votes;
            now_in    = cand_sum.eff_level;
            if (cand_sum.eff_level > peak_ff) begin
               peak_in = cand_sum.eff_level;
            end
            count_in = count_ff + COUNT_W'(1);
         end else begin
            rsp_status_in = ST_SWITCH_FAIL;
         end
      end
   end

   dmva_level_max u_next_max (
      .votes       (votes_in),
      .floor_level (floor_level),
      .sum         (next_sum)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         votes_ff     <= {NUM_CLIENTS{NO_VOTE}};
         now_ff       <= '0;
         peak_ff      <= '0;
         count_ff     <= '0;
         ready_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            votes_ff <= votes_in;
            now_ff   <= now_in;
            peak_ff  <= peak_in;
            count_ff <= count_in;
            ready_ff <= ready_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff     <= opcode_type'(req_tuser[0]);
         in_client_ff <= req_tdata[3:0];
         in_level_ff  <= req_tdata[7:4];
         in_ok_ff     <= req_tdata[8];
      end
      if (fire) begin
         rsp_status_ff    <= rsp_status_in;
         rsp_sw_ff        <= rsp_sw_in;
         rsp_req_level_ff <= rsp_req_level_in;
         rsp_all_ff       <= ready_in && next_sum.all_none;
      end
   end

   // The response shows the state as it stood right after the request.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_all_ff, count_ff, peak_ff, now_ff,
                        rsp_req_level_ff, rsp_sw_ff};

   `DMVA_ASSERT(a_count_only_on_commit, clock, reset,
      (count_ff != $past(count_ff)) |-> $past(commit_ok && fire))
   `DMVA_ASSERT(a_peak_covers_now, clock, reset,
      ready_ff |-> (peak_ff >= now_ff))
   `DMVA_ASSERT(a_switch_status, clock, reset,
      (rsp_valid_ff && rsp_sw_ff) |->
         (rsp_status_ff == ST_OK || rsp_status_ff == ST_SWITCH_FAIL))
   `DMVA_ASSERT(a_state_held_without_fire, clock, reset,
      !$past(fire) |-> ($stable(now_ff) && $stable(ready_ff) && $stable(votes_ff)))

endmodule

`default_nettype wire
